// ===== rtl/core/schash_pkg.sv =====
// Shared types and constants of the syndrome correction hash table.
// Depends on nothing; the top, front and back files refer to it by scoped name, the testbench imports it.
package schash_pkg;

	localparam int SYNDROME_BITS   = 16;
	localparam int CORRECTION_BITS = 32;
	// Home slot is syndrome modulo depth: keep the depth a power of two
	localparam int TABLE_DEPTH     = 256;
	localparam int SLOT_W          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ENTRY_W         = SYNDROME_BITS + CORRECTION_BITS;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [SYNDROME_BITS-1:0]   key_t;
	typedef logic [CORRECTION_BITS-1:0] corr_t;
	typedef logic [SLOT_W-1:0]          slot_t;
	typedef logic [ENTRY_W-1:0]         entry_t;
	typedef logic [QPTR_W-1:0]          qptr_t;
	typedef logic [QCNT_W-1:0]          qcnt_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// Classified word handed from front to back
	typedef struct packed {
		op_t   op;
		key_t  key;
		corr_t corr;
		slot_t home;
	} item_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_INS,
		B_LOOK,
		B_EMIT
	} back_state_t;

endpackage

// ===== rtl/core/syndrome_correction_hash_table.sv =====
// Syndrome correction hash table: open addressing with linear probing.
// Channels: input queue (push/full) takes operation, syndrome and correction;
// result queue (empty/pop) gives found and hit_correction, one word per lookup,
// none per insert. An input word is taken when push is high and full is low;
// a result word leaves when pop is high and empty is low.
// Flow: the back end takes a word from the front queue in its idle state. An
// insert then checks the occupancy flags slot by slot from the home slot and
// writes the first free one, or slot 0 on a full table. A lookup reads the
// entry RAM slot by slot, resolves each probe from the registered read data and
// loads the result register from its emit state. The probe loop, one slot per
// cycle through the flags (insert) or the RAM read port (lookup), sets the rate.
// Reset clears all occupancy flags at once; the table is usable right away.
// A stalled result holds in the output register; the probe engine waits in its
// emit state, and the two-word front queue keeps taking words until it fills.
// Depends on schash_pkg, schash_front, schash_back, schash_ram.
module syndrome_correction_hash_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               operation,
	input  logic [schash_pkg::SYNDROME_BITS-1:0]   syndrome,
	input  logic [schash_pkg::CORRECTION_BITS-1:0] correction,
	output logic                               empty,
	input  logic                               pop,
	output logic                               found,
	output logic [schash_pkg::CORRECTION_BITS-1:0] hit_correction
);

	logic              q_valid;
	logic              q_take;
	schash_pkg::item_t q_item;

	schash_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (schash_pkg::op_t'(operation)),
		.syndrome   (syndrome),
		.correction (correction),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_take     (q_take)
	);

	schash_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_take         (q_take),
		.empty          (empty),
		.pop            (pop),
		.found          (found),
		.hit_correction (hit_correction)
	);

endmodule

// ===== rtl/core/schash_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module schash_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/schash_front.sv =====
// Front end: accept words, compute the home slot and queue them for the back end.
// Depends on schash_pkg.
module schash_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  schash_pkg::op_t      operation,
	input  schash_pkg::key_t     syndrome,
	input  schash_pkg::corr_t    correction,
	output logic                 q_valid,
	output schash_pkg::item_t    q_item,
	input  logic                 q_take
);

	schash_pkg::item_t fifo_q [schash_pkg::QUEUE_DEPTH];
	schash_pkg::qptr_t wr_ptr_q;
	schash_pkg::qptr_t rd_ptr_q;
	schash_pkg::qcnt_t cnt_q;
	schash_pkg::item_t in_item;
	logic              push_fire;
	logic              take_fire;

	// Classify the incoming word: home slot is the low bits of the syndrome
	always_comb begin
		in_item.op   = operation;
		in_item.key  = syndrome;
		in_item.corr = correction;
		in_item.home = schash_pkg::slot_t'(syndrome % schash_pkg::TABLE_DEPTH);
	end

	assign full      = (cnt_q == schash_pkg::qcnt_t'(schash_pkg::QUEUE_DEPTH));
	assign q_valid   = (cnt_q != '0);
	assign q_item    = fifo_q[rd_ptr_q];
	assign push_fire = push && !full;
	assign take_fire = q_take && q_valid;

	// Store accepted words
	always_ff @(posedge clk) begin
		if (push_fire) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == schash_pkg::qptr_t'(schash_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (take_fire) begin
				rd_ptr_q <= (rd_ptr_q == schash_pkg::qptr_t'(schash_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !take_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take_fire && !push_fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Count never passes the queue depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= schash_pkg::qcnt_t'(schash_pkg::QUEUE_DEPTH))
		else $error("front queue count overflow");

	// Count rises by one on a push with no take
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !take_fire) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("front queue count did not advance on push");

	// A full queue holds its words
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !take_fire) |=> full && $stable(rd_ptr_q))
		else $error("front queue lost a word while full");

endmodule

// ===== rtl/core/schash_back.sv =====
// Back end: probe engine over occupancy flags and entry RAM, plus the result register.
// Depends on schash_pkg and schash_ram.
module schash_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  schash_pkg::item_t    q_item,
	output logic                 q_take,
	output logic                 empty,
	input  logic                 pop,
	output logic                 found,
	output schash_pkg::corr_t    hit_correction
);

	schash_pkg::back_state_t state_q, state_d;
	schash_pkg::slot_t       slot_q, slot_d;
	schash_pkg::slot_t       cnt_q, cnt_d;
	schash_pkg::key_t        key_q, key_d;
	schash_pkg::corr_t       corr_q, corr_d;
	logic                    res_found_q, res_found_d;
	logic                    pend_s1, pend_d;
	logic                    occ_s1, occ_d;
	logic                    last_s1, last_d;
	logic                    out_valid_q;
	logic                    found_q;
	schash_pkg::corr_t       corr_out_q;
	logic                    load_out;
	logic                    pop_fire;
	logic [schash_pkg::TABLE_DEPTH-1:0] occ_q;

	schash_pkg::slot_t  slot_nxt;
	logic               probe_last;
	logic               we;
	schash_pkg::slot_t  waddr;
	logic               re;
	schash_pkg::entry_t rdata;
	schash_pkg::key_t   rd_key;
	schash_pkg::corr_t  rd_corr;
	logic               hit;

	schash_ram #(
		.WIDTH (schash_pkg::ENTRY_W),
		.DEPTH (schash_pkg::TABLE_DEPTH)
	) u_entries (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({key_q, corr_q}),
		.re    (re),
		.raddr (slot_q),
		.rdata (rdata)
	);

	// Split the read entry and compare against the key
	assign rd_key   = rdata[schash_pkg::ENTRY_W-1:schash_pkg::CORRECTION_BITS];
	assign rd_corr  = rdata[schash_pkg::CORRECTION_BITS-1:0];
	assign hit      = pend_s1 && occ_s1 && (rd_key == key_q);
	assign slot_nxt = (slot_q == schash_pkg::slot_t'(schash_pkg::TABLE_DEPTH - 1)) ?
		'0 : slot_q + 1'b1;
	assign probe_last = (cnt_q == schash_pkg::slot_t'(schash_pkg::TABLE_DEPTH - 1));

	assign pop_fire = pop && out_valid_q;
	assign empty    = !out_valid_q;
	assign found    = found_q;
	assign hit_correction = corr_out_q;

	// Next state and probe control
	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		cnt_d       = cnt_q;
		key_d       = key_q;
		corr_d      = corr_q;
		res_found_d = res_found_q;
		pend_d      = 1'b0;
		occ_d       = occ_s1;
		last_d      = last_s1;
		q_take      = 1'b0;
		we          = 1'b0;
		waddr       = slot_q;
		re          = 1'b0;
		load_out    = 1'b0;
		unique case (state_q)
			schash_pkg::B_IDLE: begin
				q_take = q_valid;
				if (q_valid) begin
					key_d  = q_item.key;
					corr_d = q_item.corr;
					slot_d = q_item.home;
					cnt_d  = '0;
					state_d = (q_item.op == schash_pkg::OP_INSERT) ?
						schash_pkg::B_INS : schash_pkg::B_LOOK;
				end
			end
			schash_pkg::B_INS: begin
				// Take the first free slot; on a full table overwrite slot 0
				if (!occ_q[slot_q]) begin
					we      = 1'b1;
					state_d = schash_pkg::B_IDLE;
				end else if (probe_last) begin
					we      = 1'b1;
					waddr   = '0;
					state_d = schash_pkg::B_IDLE;
				end else begin
					slot_d = slot_nxt;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			schash_pkg::B_LOOK: begin
				// Resolve the probe in flight, else issue the next one
				if (hit) begin
					res_found_d = 1'b1;
					corr_d      = rd_corr;
					state_d     = schash_pkg::B_EMIT;
				end else if (pend_s1 && last_s1) begin
					res_found_d = 1'b0;
					corr_d      = '0;
					state_d     = schash_pkg::B_EMIT;
				end else begin
					re     = 1'b1;
					pend_d = 1'b1;
					occ_d  = occ_q[slot_q];
					last_d = probe_last;
					slot_d = slot_nxt;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			schash_pkg::B_EMIT: begin
				// Hand the result over once the output register frees up
				if (!out_valid_q || pop) begin
					load_out = 1'b1;
					state_d  = schash_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = schash_pkg::B_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= schash_pkg::B_IDLE;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			occ_q       <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= pend_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop_fire) begin
				out_valid_q <= 1'b0;
			end
			if (we) begin
				occ_q[waddr] <= 1'b1;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		slot_q      <= slot_d;
		cnt_q       <= cnt_d;
		key_q       <= key_d;
		corr_q      <= corr_d;
		res_found_q <= res_found_d;
		occ_s1      <= occ_d;
		last_s1     <= last_d;
		if (load_out) begin
			found_q    <= res_found_q;
			corr_out_q <= corr_q;
		end
	end

	// A new result appears only out of the emit state
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_valid_q) && out_valid_q) |-> $past(state_q == schash_pkg::B_EMIT))
		else $error("result appeared outside emit");

	// A miss carries a zero correction
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (corr_out_q == '0))
		else $error("miss with nonzero correction");

	// Entries are written only by an insert
	a_write_ins: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == schash_pkg::B_INS))
		else $error("entry write outside insert");

	// A probe in flight belongs to a lookup
	a_pend_look: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == schash_pkg::B_LOOK))
		else $error("probe in flight outside lookup");

	// A waiting result holds until popped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> out_valid_q && $stable(corr_out_q) && $stable(found_q))
		else $error("waiting result changed");

endmodule

// ===== dv/tb_syndrome_correction_hash_table.sv =====
// Self-checking testbench for the syndrome correction hash table: queued driver,
// clocked monitor and a linear-probing table predictor checked word by word.
// Depends on schash_pkg and the syndrome_correction_hash_table RTL.
module tb_syndrome_correction_hash_table;
	import schash_pkg::*;

	localparam int STALL_LIMIT = 12 * (TABLE_DEPTH + 8);
	localparam int DRAIN_CYCLES = 3 * (TABLE_DEPTH + 4);

	typedef struct {
		op_t   op;
		key_t  key;
		corr_t corr;
	} table_req_t;

	typedef struct {
		logic  hit;
		corr_t corr;
	} lookup_ans_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic operation;
	key_t syndrome;
	corr_t correction;
	logic empty;
	logic pop;
	logic found;
	corr_t hit_correction;

	// Predicted table contents
	bit    slot_used [TABLE_DEPTH];
	key_t  slot_key  [TABLE_DEPTH];
	corr_t slot_corr [TABLE_DEPTH];

	table_req_t  pending_reqs[$];
	lookup_ans_t lookup_answers[$];
	table_req_t  cur_req;
	bit          req_taken;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          mismatch_count;

	// Generator-side view: keys already queued for insert, and how many
	key_t inserted_keys[$];
	int   inserts_queued;

	syndrome_correction_hash_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.operation     (operation),
		.syndrome      (syndrome),
		.correction    (correction),
		.empty         (empty),
		.pop           (pop),
		.found         (found),
		.hit_correction(hit_correction)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one accepted word to the predicted table; queue the answer of a lookup
	function automatic void table_apply(input table_req_t w);
		int slot;
		int hit_slot;
		bit hit;
		lookup_ans_t ans;
		slot = int'(w.key) % TABLE_DEPTH;
		hit_slot = 0;
		hit = 1'b0;
		if (w.op == OP_INSERT) begin
			for (int n = 0; n < TABLE_DEPTH && !hit; n++) begin
				if (!slot_used[slot]) begin
					hit_slot = slot;
					hit = 1'b1;
				end
				slot = (slot + 1) % TABLE_DEPTH;
			end
			// no free slot: slot 0 takes the new entry
			slot_used[hit_slot] = 1'b1;
			slot_key[hit_slot] = w.key;
			slot_corr[hit_slot] = w.corr;
		end else begin
			for (int n = 0; n < TABLE_DEPTH && !hit; n++) begin
				if (slot_used[slot] && slot_key[slot] == w.key) begin
					hit_slot = slot;
					hit = 1'b1;
				end
				slot = (slot + 1) % TABLE_DEPTH;
			end
			ans.hit = hit;
			ans.corr = hit ? slot_corr[hit_slot] : '0;
			lookup_answers.push_back(ans);
		end
	endfunction

	function automatic void queue_req(input op_t op, input key_t key, input corr_t corr);
		table_req_t w;
		w.op = op;
		w.key = key;
		w.corr = corr;
		pending_reqs.push_back(w);
		if (op == OP_INSERT) begin
			inserted_keys.push_back(key);
			inserts_queued++;
		end
	endfunction

	function automatic corr_t pick_corr();
		int r;
		r = $urandom_range(99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return corr_t'($urandom);
	endfunction

	function automatic key_t known_key();
		return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
	endfunction

	// Insert keys: fresh, same home as a known key, duplicates, and edge keys
	function automatic key_t pick_insert_key();
		int r;
		key_t k;
		r = $urandom_range(99);
		if (r < 40 || inserted_keys.size() == 0) return key_t'($urandom_range(16'hFFFF));
		k = known_key();
		if (r < 70) return {8'($urandom_range(255)), k[7:0]};
		if (r < 85) return k;
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return {8'($urandom_range(255)), 8'hFF};
			default: return {8'($urandom_range(255)), 8'h00};
		endcase
	endfunction

	// Lookup keys: mostly hits, some misses that walk a cluster
	function automatic key_t pick_lookup_key();
		int r;
		key_t k;
		r = $urandom_range(99);
		if (inserted_keys.size() == 0) return key_t'($urandom_range(16'hFFFF));
		k = known_key();
		if (r < 60) return k;
		if (r < 80) return {8'($urandom_range(255)), k[7:0]};
		return key_t'($urandom_range(16'hFFFF));
	endfunction

	function automatic void queue_random(input int count, input int insert_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < insert_pct)
				queue_req(OP_INSERT, pick_insert_key(), pick_corr());
			else
				queue_req(OP_LOOKUP, pick_lookup_key(), corr_t'($urandom));
		end
	endfunction

	// Drive the next word and the pop at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			pop <= 1'b0;
		end else begin
			if (!push || req_taken) begin
				req_taken = 1'b0;
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req = pending_reqs.pop_front();
					push <= 1'b1;
					operation <= cur_req.op;
					syndrome <= cur_req.key;
					correction <= cur_req.corr;
				end else begin
					push <= 1'b0;
				end
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		lookup_ans_t exp_ans;
		if (arst_n && push && !full) begin
			table_apply(cur_req);
			req_taken = 1'b1;
		end
		if (arst_n && pop && !empty) begin
			if (lookup_answers.size() == 0) begin
				$error("result word with no lookup waiting: found %0d, hit_correction %08h",
					found, hit_correction);
				mismatch_count++;
			end else begin
				exp_ans = lookup_answers.pop_front();
				if (found !== exp_ans.hit) begin
					$error("found: expected %0d, actual %0d", exp_ans.hit, found);
					mismatch_count++;
				end
				if (hit_correction !== exp_ans.corr) begin
					$error("hit_correction: expected %08h, actual %08h",
						exp_ans.corr, hit_correction);
					mismatch_count++;
				end
			end
		end
	end

	// End the run when nothing moves for too long while work remains
	initial begin : watchdog
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else if (push || pending_reqs.size() != 0 || lookup_answers.size() != 0)
				stall_cycles++;
			else
				stall_cycles = 0;
		end
		$display("tb_syndrome_correction_hash_table: FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		operation = 1'b0;
		syndrome = '0;
		correction = '0;
		req_taken = 1'b0;
		mismatch_count = 0;
		inserts_queued = 0;
		send_idle_pct = 21;
		recv_idle_pct = 88;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, extreme keys and words, wrap-around, duplicates
		queue_req(OP_LOOKUP, 16'h0000, '0);
		queue_req(OP_LOOKUP, 16'hFFFF, '1);
		queue_req(OP_INSERT, 16'h0000, 32'hFFFF_FFFF);
		queue_req(OP_INSERT, 16'hFFFF, 32'h0000_0000);
		queue_req(OP_LOOKUP, 16'h0000, '0);
		queue_req(OP_LOOKUP, 16'hFFFF, '0);
		queue_req(OP_INSERT, 16'h12FF, 32'h1234_5678);
		queue_req(OP_INSERT, 16'h00FF, 32'h8765_4321);
		queue_req(OP_LOOKUP, 16'h00FF, '0);
		queue_req(OP_LOOKUP, 16'h34FF, '0);
		queue_req(OP_INSERT, 16'h0000, 32'hC0DE_0001);
		queue_req(OP_LOOKUP, 16'h0000, '0);
		queue_req(OP_INSERT, 16'h5A5A, 32'h5A5A_5A5A);
		queue_req(OP_INSERT, 16'hA5A5, 32'hA5A5_A5A5);
		queue_req(OP_LOOKUP, 16'h5A5A, '1);
		queue_req(OP_LOOKUP, 16'hA5A5, '0);
		queue_req(OP_LOOKUP, 16'h0100, '0);

		// Slow receiver
		queue_random(160, 55);
		while (push || pending_reqs.size() != 0) @(posedge clk);

		// Slow sender
		send_idle_pct = 88;
		recv_idle_pct = 21;
		queue_random(160, 55);
		while (push || pending_reqs.size() != 0) @(posedge clk);

		// Full rate: top the table off, then keep going on a full table
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (inserts_queued < TABLE_DEPTH)
			queue_req(OP_INSERT, pick_insert_key(), pick_corr());
		queue_random(150, 45);
		while (push || pending_reqs.size() != 0 || lookup_answers.size() != 0)
			@(posedge clk);

		// Let trailing inserts finish and catch any stray result
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (lookup_answers.size() != 0) begin
			$error("%0d lookup results never arrived", lookup_answers.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("tb_syndrome_correction_hash_table: PASS");
		else
			$display("tb_syndrome_correction_hash_table: FAIL");
		$finish;
	end

endmodule
